// File: rtl/mh_pkg.sv
// Shared types and constants for the magnetometer heading unit.
// No dependencies; imported by every module of the block.
package mh_pkg;

  // Angle accumulator: 2^-16 degree units, holds +-190 degrees with margin
  localparam int ZW = 26;
  // Full circle in 1/64 degree units
  localparam logic [14:0] ANGLE_FULL = 15'd23040;
  // Quarter turn in accumulator units
  localparam logic signed [ZW-1:0] QUARTER_TURN = 26'sd5898240;
  // Rounding offset and shift from 2^-16 to 1/64 degree
  localparam logic signed [ZW-1:0] ROUND_HALF = 26'sd512;
  localparam int ROUND_SHIFT = 10;
  localparam int TABLE_LEN = 24;

  localparam logic [14:0] REF_RESET = 15'd0;
  localparam logic [14:0] WINDOW_RESET = 15'd1920;  // 30 degrees

  // Register index, taken from paddr[2]
  localparam logic REG_REFERENCE = 1'b0;
  localparam logic REG_WINDOW = 1'b1;

  typedef struct packed {
    logic [14:0] reference_heading;
    logic [14:0] goal_window;
  } cfg_t;

  // atan(2^-i) in 2^-16 degree units
  function automatic logic signed [ZW-1:0] atan_tab(input int idx);
    logic signed [ZW-1:0] v;
    v = '0;
    unique case (idx)
      0: v = 26'sd2949120;
      1: v = 26'sd1740967;
      2: v = 26'sd919879;
      3: v = 26'sd466945;
      4: v = 26'sd234379;
      5: v = 26'sd117304;
      6: v = 26'sd58666;
      7: v = 26'sd29335;
      8: v = 26'sd14668;
      9: v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      20: v = 26'sd4;
      21: v = 26'sd2;
      22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/mh_cfg.sv
// APB-style register file: reference heading and goal window.
// Depends on mh_pkg.
module mh_cfg (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output mh_pkg::cfg_t cfg
);
  import mh_pkg::*;

  logic [14:0] ref_r, ref_nxt;
  logic [14:0] win_r, win_nxt;
  logic        wr_en;

  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    ref_nxt = ref_r;
    win_nxt = win_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_REFERENCE: ref_nxt = pwdata[14:0];
        REG_WINDOW:    win_nxt = pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= REF_RESET;
      win_r <= WINDOW_RESET;
    end else begin
      ref_r <= ref_nxt;
      win_r <= win_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_REFERENCE: prdata = {17'd0, ref_r};
      REG_WINDOW:    prdata = {17'd0, win_r};
      default: ;
    endcase
  end

  assign cfg.reference_heading = ref_r;
  assign cfg.goal_window = win_r;

endmodule

// File: rtl/mh_prerot.sv
// Input stage: sign-extends and scales the sample, turns a left half-plane
// vector by a quarter turn. Depends on mh_pkg.
module mh_prerot #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int DW = SAMPLE_WIDTH + 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  output logic                          rdy_o,
  input  logic [15:0]                   mag_x,
  input  logic [15:0]                   mag_y,
  output logic                          vld_o,
  input  logic                          rdy_i,
  output logic signed [DW-1:0]          cx_o,
  output logic signed [DW-1:0]          cy_o,
  output logic signed [mh_pkg::ZW-1:0]  z_o,
  output logic                          zero_o
);
  import mh_pkg::*;

  logic                 vld_r;
  logic                 en;
  logic signed [DW-1:0] sx, sy;
  logic signed [DW-1:0] cx_nxt, cy_nxt, cx_r, cy_r;
  logic signed [ZW-1:0] z_nxt, z_r;
  logic                 zero_nxt, zero_r;

  assign en = !vld_r || rdy_i;
  assign rdy_o = en;

  // low SAMPLE_WIDTH bits, sign-extended and scaled by 256
  assign sx = $signed({{(DW-SAMPLE_WIDTH-8){mag_x[SAMPLE_WIDTH-1]}},
                       mag_x[SAMPLE_WIDTH-1:0], 8'd0});
  assign sy = $signed({{(DW-SAMPLE_WIDTH-8){mag_y[SAMPLE_WIDTH-1]}},
                       mag_y[SAMPLE_WIDTH-1:0], 8'd0});

  // vector is (y, x): cx from mag_y, cy from mag_x
  always_comb begin
    cx_nxt = sy;
    cy_nxt = sx;
    z_nxt = '0;
    zero_nxt = (mag_x[SAMPLE_WIDTH-1:0] == '0) && (mag_y[SAMPLE_WIDTH-1:0] == '0);
    if (sy[DW-1]) begin
      if (!sx[DW-1]) begin
        cx_nxt = sx;
        cy_nxt = -sy;
        z_nxt = QUARTER_TURN;
      end else begin
        cx_nxt = -sx;
        cy_nxt = sy;
        z_nxt = -QUARTER_TURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_i) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      z_r <= z_nxt;
      zero_r <= zero_nxt;
    end
  end

  assign vld_o = vld_r;
  assign cx_o = cx_r;
  assign cy_o = cy_r;
  assign z_o = z_r;
  assign zero_o = zero_r;

endmodule

// File: rtl/mh_cordic_stage.sv
// One vectoring micro-rotation with its pipeline register.
// Depends on mh_pkg for the arctangent table.
module mh_cordic_stage #(
  parameter int DW = 27,
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  output logic                          rdy_o,
  input  logic signed [DW-1:0]          cx_i,
  input  logic signed [DW-1:0]          cy_i,
  input  logic signed [mh_pkg::ZW-1:0]  z_i,
  input  logic                          zero_i,
  output logic                          vld_o,
  input  logic                          rdy_i,
  output logic signed [DW-1:0]          cx_o,
  output logic signed [DW-1:0]          cy_o,
  output logic signed [mh_pkg::ZW-1:0]  z_o,
  output logic                          zero_o
);
  import mh_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = atan_tab(SHIFT);

  logic                 vld_r;
  logic                 en;
  logic signed [DW-1:0] dx, dy;
  logic signed [DW-1:0] cx_nxt, cy_nxt, cx_r, cy_r;
  logic signed [ZW-1:0] z_nxt, z_r;
  logic                 zero_r;

  assign en = !vld_r || rdy_i;
  assign rdy_o = en;

  assign dx = cy_i >>> SHIFT;
  assign dy = cx_i >>> SHIFT;

  always_comb begin
    if (!cy_i[DW-1]) begin
      cx_nxt = cx_i + dx;
      cy_nxt = cy_i - dy;
      z_nxt = z_i + ATAN;
    end else begin
      cx_nxt = cx_i - dx;
      cy_nxt = cy_i + dy;
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_i) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      z_r <= z_nxt;
      zero_r <= zero_i;
    end
  end

  assign vld_o = vld_r;
  assign cx_o = cx_r;
  assign cy_o = cy_r;
  assign z_o = z_r;
  assign zero_o = zero_r;

endmodule

// File: rtl/mh_finish.sv
// Rounds and wraps the angle, then forms the flipped heading and the
// goal-window flag in the output register. Depends on mh_pkg.
module mh_finish (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  output logic                          rdy_o,
  input  logic signed [mh_pkg::ZW-1:0]  z_i,
  input  logic                          zero_i,
  input  mh_pkg::cfg_t                  cfg,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [14:0]                   out_heading_out,
  output logic                          out_on_goal
);
  import mh_pkg::*;

  localparam int AW = ZW - ROUND_SHIFT;

  logic                 en_a, en_b;
  logic                 vld_a_r, vld_b_r;
  logic signed [ZW-1:0] z_rnd;
  logic signed [AW-1:0] a_s;
  logic signed [AW:0]   a_wrap;
  logic [14:0]          a_nxt, a_r;
  logic [14:0]          head_nxt, head_r;
  logic signed [15:0]   diff;
  logic [15:0]          diff_abs;
  logic                 face_nxt, face_r;

  assign en_b = !vld_b_r || !out_stall;
  assign en_a = !vld_a_r || en_b;
  assign rdy_o = en_a;

  // round half up to 1/64 degree, then wrap negatives by a full turn
  assign z_rnd = (zero_i ? '0 : z_i) + ROUND_HALF;
  assign a_s = AW'(z_rnd >>> ROUND_SHIFT);
  assign a_wrap = a_s[AW-1] ? ((AW+1)'(a_s) + $signed({1'b0, ANGLE_FULL}))
                            : (AW+1)'(a_s);
  assign a_nxt = a_wrap[14:0];

  // no wrap at 0/360 in the window compare
  assign diff = $signed({1'b0, a_r}) - $signed({1'b0, cfg.reference_heading});
  assign diff_abs = diff[15] ? 16'(-diff) : 16'(diff);
  assign face_nxt = diff_abs <= {1'b0, cfg.goal_window};
  assign head_nxt = ANGLE_FULL - a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (en_a) vld_a_r <= vld_i;
      if (en_b) vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && vld_i) begin
      a_r <= a_nxt;
    end
    if (en_b && vld_a_r) begin
      head_r <= head_nxt;
      face_r <= face_nxt;
    end
  end

  assign out_valid = vld_b_r;
  assign out_heading_out = head_r;
  assign out_on_goal = face_r;

endmodule

// File: rtl/magnetometer_heading_unit.sv
// Compass heading unit: samples in, flipped CORDIC heading and goal flag out.
// Depends on mh_pkg, mh_cfg, mh_prerot, mh_cordic_stage and mh_finish.
//
// Usage:
//   Input channel: in_mag_x / in_mag_y with in_valid, in_stall. A beat is
//   taken when in_valid is high and in_stall low.
//   Output channel: out_heading_out (1/64 degree, 360 minus atan2(x, y)
//   wrapped to 0..360) and out_on_goal, with out_valid, out_stall.
//   Registers over the APB-style port: 0x0 reference heading, 0x4 goal
//   window (both 15 bits); write them only while the pipe is empty.
//   Pipeline: one input stage, one register per micro-rotation, a
//   round/wrap stage and the output register. Throughput: one beat per
//   cycle while out_stall is low.
//   Reset empties the pipe and loads reference 0, window 1920 (30 deg).
//   When the receiver stalls, each stage holds its beat; bubbles ahead of
//   the stall still fill, and in_stall rises only once the pipe is full.
module magnetometer_heading_unit #(
  parameter int CORDIC_STAGES = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_mag_x,
  input  logic [15:0] in_mag_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_heading_out,
  output logic        out_on_goal,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mh_pkg::*;

  localparam int NSTG = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int DW = SAMPLE_WIDTH + 11;

  cfg_t                 cfg;
  logic                 in_rdy;
  logic                 vld_s  [NSTG+1];
  logic                 rdy_s  [NSTG+1];
  logic signed [DW-1:0] cx_s   [NSTG+1];
  logic signed [DW-1:0] cy_s   [NSTG+1];
  logic signed [ZW-1:0] z_s    [NSTG+1];
  logic                 zero_s [NSTG+1];

  mh_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mh_prerot #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .DW           (DW)
  ) u_prerot (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (in_valid),
    .rdy_o  (in_rdy),
    .mag_x  (in_mag_x),
    .mag_y  (in_mag_y),
    .vld_o  (vld_s[0]),
    .rdy_i  (rdy_s[0]),
    .cx_o   (cx_s[0]),
    .cy_o   (cy_s[0]),
    .z_o    (z_s[0]),
    .zero_o (zero_s[0])
  );

  assign in_stall = !in_rdy;

  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    mh_cordic_stage #(
      .DW    (DW),
      .SHIFT (k)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld_s[k]),
      .rdy_o  (rdy_s[k]),
      .cx_i   (cx_s[k]),
      .cy_i   (cy_s[k]),
      .z_i    (z_s[k]),
      .zero_i (zero_s[k]),
      .vld_o  (vld_s[k+1]),
      .rdy_i  (rdy_s[k+1]),
      .cx_o   (cx_s[k+1]),
      .cy_o   (cy_s[k+1]),
      .z_o    (z_s[k+1]),
      .zero_o (zero_s[k+1])
    );
  end

  mh_finish u_finish (
    .clk             (clk),
    .rst_n           (rst_n),
    .vld_i           (vld_s[NSTG]),
    .rdy_o           (rdy_s[NSTG]),
    .z_i             (z_s[NSTG]),
    .zero_i          (zero_s[NSTG]),
    .cfg             (cfg),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_heading_out (out_heading_out),
    .out_on_goal     (out_on_goal)
  );

endmodule

// File: sim/tb_magnetometer_heading_unit.sv
// Self-checking bench for magnetometer_heading_unit: directed table, then random samples.
// Needs mh_pkg and the unit's RTL; the expected headings come from a CORDIC model kept here.
`timescale 1ns / 100ps

module tb_magnetometer_heading_unit;
  import mh_pkg::*;

  localparam int CORDIC_N = 16;
  localparam int SAMPLE_W = 16;
  localparam int DIR_ROWS = 20;
  localparam int SETTINGS_N = 6;
  localparam int RAND_PER_SETTING = 255;
  localparam int HOLD_CYCLES = 200;
  localparam logic [2:0] ADDR_REFERENCE = {REG_REFERENCE, 2'b00};
  localparam logic [2:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};

  typedef struct packed {
    logic [14:0] hdg;
    logic        fac;
  } heading_exp_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        known;
    logic [14:0] hdg;
    logic        fac;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_mag_x = '0;
  logic [15:0] in_mag_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [14:0] out_heading_out;
  logic        out_on_goal;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // atan(2^-i), 2^-16 degree
  longint atan_deg16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // zero vector rows: angle 0, so 360 degrees out and on-goal with reset registers
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{16'h0000, 16'h0000, 1'b1, ANGLE_FULL, 1'b1},
    '{16'h7FFF, 16'h0000, 1'b0, 15'd0, 1'b0},
    '{16'h8000, 16'h0000, 1'b0, 15'd0, 1'b0},
    '{16'h0000, 16'h7FFF, 1'b0, 15'd0, 1'b0},
    '{16'h0000, 16'h8000, 1'b0, 15'd0, 1'b0},
    '{16'h7FFF, 16'h7FFF, 1'b0, 15'd0, 1'b0},
    '{16'h8000, 16'h8000, 1'b0, 15'd0, 1'b0},
    '{16'h7FFF, 16'h8000, 1'b0, 15'd0, 1'b0},
    '{16'h8000, 16'h7FFF, 1'b0, 15'd0, 1'b0},
    '{16'h0001, 16'h0000, 1'b0, 15'd0, 1'b0},
    '{16'hFFFF, 16'h0000, 1'b0, 15'd0, 1'b0},
    '{16'h0000, 16'h0001, 1'b0, 15'd0, 1'b0},
    '{16'h0000, 16'hFFFF, 1'b0, 15'd0, 1'b0},
    '{16'h0001, 16'h0001, 1'b0, 15'd0, 1'b0},
    '{16'hFFFF, 16'hFFFF, 1'b0, 15'd0, 1'b0},
    '{16'hFFFF, 16'h7FFF, 1'b0, 15'd0, 1'b0},
    '{16'h0001, 16'h8000, 1'b0, 15'd0, 1'b0},
    '{16'hFFFF, 16'h8000, 1'b0, 15'd0, 1'b0},
    '{16'h0064, 16'hFF9C, 1'b0, 15'd0, 1'b0},
    '{16'h0000, 16'h0000, 1'b1, ANGLE_FULL, 1'b1}
  };

  heading_exp_t pending_headings[$];
  heading_exp_t want;
  logic [14:0]  ref_hdg = REF_RESET;
  logic [14:0]  win_hdg = WINDOW_RESET;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  logic         hold_tog = 1'b0;
  logic         hold_seen = 1'b0;
  int           hold_left = 0;
  int           mismatches = 0;
  int           headings_checked = 0;
  int           samples_sent = 0;
  int           stalled_cycles = 0;

  magnetometer_heading_unit #(
    .CORDIC_STAGES(CORDIC_N),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mag_x(in_mag_x), .in_mag_y(in_mag_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_heading_out(out_heading_out), .out_on_goal(out_on_goal),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic heading_exp_t predict_heading(input logic [15:0] mx, input logic [15:0] my,
                                                   input logic [14:0] ref_h,
                                                   input logic [14:0] win_h);
    heading_exp_t r;
    longint cx, cy, z, t, dx, dy, ang, diff;
    int n, i;
    // vector is (y, x): angle = atan2(x, y)
    cx = ((longint'($signed(my)) <<< (64 - SAMPLE_W)) >>> (64 - SAMPLE_W)) * 256;
    cy = ((longint'($signed(mx)) <<< (64 - SAMPLE_W)) >>> (64 - SAMPLE_W)) * 256;
    z = 0;
    if (cx != 0 || cy != 0) begin
      if (cx < 0) begin
        if (cy >= 0) begin
          t = cx; cx = cy; cy = -t;
          z = 90 * 65536;
        end else begin
          t = cx; cx = -cy; cy = t;
          z = -90 * 65536;
        end
      end
      n = (CORDIC_N > 24) ? 24 : CORDIC_N;
      for (i = 0; i < n; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx += dx; cy -= dy; z += atan_deg16[i];
        end else begin
          cx -= dx; cy += dy; z -= atan_deg16[i];
        end
      end
    end
    ang = (z + 512) >>> 10;
    if (ang < 0) ang += 23040;
    if (ang < 0) ang = 0;
    if (ang > 23040) ang = 23040;
    diff = ang - longint'(ref_h);
    if (diff < 0) diff = -diff;
    t = 23040 - ang;
    r.hdg = t[14:0];
    r.fac = (diff <= longint'(win_h));
    return r;
  endfunction

  function automatic logic [15:0] corner_value();
    logic [15:0] v;
    case ($urandom_range(4))
      0: v = 16'h8000;
      1: v = 16'hFFFF;
      2: v = 16'h0000;
      3: v = 16'h0001;
      default: v = 16'h7FFF;
    endcase
    return v;
  endfunction

  // output side: random stall, long hold-off on request, result check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_headings.size() == 0) begin
        $display("%0t: heading beat with nothing expected: heading %0d on_goal %0b",
                 $time, out_heading_out, out_on_goal);
        mismatches++;
      end else begin
        want = pending_headings.pop_front();
        headings_checked++;
        if (out_heading_out !== want.hdg) begin
          $display("%0t: heading_out expected %0d actual %0d", $time, want.hdg, out_heading_out);
          mismatches++;
        end
        if (out_on_goal !== want.fac) begin
          $display("%0t: on_goal expected %0b actual %0b", $time, want.fac,
                   out_on_goal);
          mismatches++;
        end
      end
    end
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic offer_sample(input logic [15:0] x, input logic [15:0] y, input logic known,
                              input heading_exp_t typed);
    int gap = 0;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct && gap < 20) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mag_x <= x;
    in_mag_y <= y;
    do begin
      @(posedge clk);
      if (in_stall) stalled_cycles++;
    end while (in_stall);
    if (known) pending_headings.push_back(typed);
    else pending_headings.push_back(predict_heading(x, y, ref_hdg, win_hdg));
    samples_sent++;
  endtask

  // called straight after an accepted beat, so valid is lowered once in that step
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [14:0] value);
    logic [31:0] data;
    data = ($urandom & 32'hFFFF8000) | {17'd0, value};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_REFERENCE) ref_hdg = data[14:0];
    else win_hdg = data[14:0];
    // bus idle between transfers
    @(posedge clk);
  endtask

  task automatic set_idle(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  initial begin
    logic [14:0]  ref_set [SETTINGS_N];
    logic [14:0]  win_set [SETTINGS_N];
    logic [15:0]  sx, sy;
    logic [31:0]  r;
    heading_exp_t typed;
    int ph, k, i;

    ref_set[0] = 15'd0;     win_set[0] = 15'd0;
    ref_set[1] = 15'd23039; win_set[1] = 15'd23040;
    ref_set[2] = 15'h7FFF;  win_set[2] = 15'h7FFF;
    ref_set[3] = 15'd11520; win_set[3] = 15'd1920;
    ref_set[4] = 15'($urandom_range(23039)); win_set[4] = 15'($urandom_range(23040));
    ref_set[5] = 15'($urandom_range(32767)); win_set[5] = 15'($urandom_range(4000));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idle(37, 76);
    for (i = 0; i < DIR_ROWS; i++) begin
      typed.hdg = dir_rows[i].hdg;
      typed.fac = dir_rows[i].fac;
      offer_sample(dir_rows[i].x, dir_rows[i].y, dir_rows[i].known, typed);
    end
    drain_pipe();

    typed = '0;
    for (ph = 0; ph < SETTINGS_N; ph++) begin
      write_reg(ADDR_REFERENCE, ref_set[ph]);
      write_reg(ADDR_WINDOW, win_set[ph]);
      if (ph < 2) set_idle(37, 76);
      else if (ph < 4) set_idle(76, 37);
      else set_idle(0, 0);
      for (k = 0; k < RAND_PER_SETTING; k++) begin
        // long output hold-off with the input flat out: pipe fills, in_stall rises
        if (ph == 4 && k == 20) hold_tog <= ~hold_tog;
        if (ph == 2 && k == 100) drain_pipe();
        r = $urandom;
        case ($urandom_range(9))
          0: begin sx = corner_value(); sy = corner_value(); end
          1: begin sx = r[3:0] - 16'd8; sy = r[19:16] - 16'd8; end
          2: begin sx = 16'h0000; sy = r[31:16]; end
          3: begin sx = r[15:0]; sy = 16'h0000; end
          default: begin sx = r[15:0]; sy = r[31:16]; end
        endcase
        offer_sample(sx, sy, 1'b0, typed);
      end
      drain_pipe();
    end

    repeat (CORDIC_N + 8) @(posedge clk);
    $display("Checked %0d headings from %0d samples (%0d directed) over %0d register settings",
             headings_checked, samples_sent, DIR_ROWS, SETTINGS_N + 1);
    $display("Both sides idled in turn; input back-pressure seen on %0d cycles", stalled_cycles);
    if (mismatches == 0 && pending_headings.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Timed out with %0d headings outstanding", pending_headings.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/mh_pkg.sv
rtl/mh_cfg.sv
rtl/mh_prerot.sv
rtl/mh_cordic_stage.sv
rtl/mh_finish.sv
rtl/magnetometer_heading_unit.sv
sim/tb_magnetometer_heading_unit.sv
